FILE: sv/ssn_pkg.sv
// Shared types, command codes and byte constants for the seven-segment
// command stream unit. No dependencies.
package ssn_pkg;

  localparam logic [1:0] CMD_ON     = 2'd0;
  localparam logic [1:0] CMD_DIGIT  = 2'd1;
  localparam logic [1:0] CMD_NUMBER = 2'd2;

  localparam logic [7:0] BYTE_DISPLAY_ON = 8'h8F;
  localparam logic [7:0] BYTE_FIXED_ADDR = 8'h44;
  localparam logic [7:0] BYTE_ADDR_BASE  = 8'hC0;

  localparam logic [13:0] NUMBER_MAX = 14'd9999;
  localparam int unsigned BIN_W       = 14;
  localparam int unsigned BCD_W       = 16;
  // two binary bits are folded into the BCD word per conversion cycle
  localparam logic [2:0]  CONV_LAST   = 3'd6;

  typedef enum logic [1:0] {
    KIND_ON,
    KIND_DIGIT,
    KIND_NUMBER
  } kind_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_CONV,
    FRONT_PUSH
  } front_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  position;
    logic [3:0]  digit;
    logic [15:0] bcd;
  } entry_t;

  typedef enum logic [1:0] {
    PHASE_MODE,
    PHASE_ADDR,
    PHASE_DATA
  } phase_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] code;
    case (d)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

FILE: sv/ssn_ifs.sv
// Valid/ready channel interfaces for the command input and the byte output.
// Standalone; payload widths are fixed by the command and byte formats.
interface cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  position;
  logic [3:0]  digit;
  logic [15:0] number;

  modport source (output valid, command, position, digit, number, input ready);
  modport sink   (input valid, command, position, digit, number, output ready);
endinterface

interface seg_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_res;
  logic       frame_start;
  logic       frame_end;
  logic       last;

  modport source (output valid, byte_res, frame_start, frame_end, last, input ready);
  modport sink   (input valid, byte_res, frame_start, frame_end, last, output ready);
endinterface

FILE: sv/ssn_front.sv
// Front end: accepts commands, saturates numbers and converts them to BCD.
// Depends on ssn_pkg and cmd_if; feeds ssn_queue.
module ssn_front (
  input  logic            clk,
  input  logic            rst,
  cmd_if.sink             cmd,
  input  logic            full,
  output logic            push,
  output ssn_pkg::entry_t push_entry
);
  import ssn_pkg::*;

  front_state_t       state, state_next;
  logic [BIN_W-1:0]   bin;
  logic [BCD_W-1:0]   bcd;
  logic [2:0]         step;
  logic               accept;

  function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] b,
                                                  input logic in_bit);
    logic [BCD_W-1:0] a;
    a = b;
    for (int i = 0; i < 4; i++) begin
      if (a[4*i +: 4] >= 4'd5) a[4*i +: 4] = a[4*i +: 4] + 4'd3;
    end
    return {a[BCD_W-2:0], in_bit};
  endfunction

  assign accept = cmd.valid && cmd.ready;

  always_comb begin
    state_next = state;
    case (state)
      FRONT_IDLE: if (accept && cmd.command == CMD_NUMBER) state_next = FRONT_CONV;
      FRONT_CONV: if (step == CONV_LAST) state_next = FRONT_PUSH;
      FRONT_PUSH: if (!full) state_next = FRONT_IDLE;
      default:    state_next = FRONT_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready           = 1'b0;
    push                = 1'b0;
    push_entry.kind     = KIND_NUMBER;
    push_entry.position = cmd.position;
    push_entry.digit    = cmd.digit;
    push_entry.bcd      = bcd;
    case (state)
      FRONT_IDLE: begin
        cmd.ready = !full;
        push      = accept && (cmd.command == CMD_ON || cmd.command == CMD_DIGIT);
        push_entry.kind = (cmd.command == CMD_ON) ? KIND_ON : KIND_DIGIT;
      end
      FRONT_PUSH: push = !full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FRONT_IDLE) begin
      // saturate and clear the BCD word on every idle cycle
      bin  <= (cmd.number > {2'b00, NUMBER_MAX}) ? NUMBER_MAX : cmd.number[BIN_W-1:0];
      bcd  <= '0;
      step <= '0;
    end else if (state == FRONT_CONV) begin
      bcd  <= dabble_bit(dabble_bit(bcd, bin[BIN_W-1]), bin[BIN_W-2]);
      bin  <= {bin[BIN_W-3:0], 2'b00};
      step <= step + 3'd1;
    end
  end

endmodule

FILE: sv/ssn_queue.sv
// Small register queue between front and back end.
// Depends on ssn_pkg; Depth must be a power of two, at least 2.
module ssn_queue #(
  parameter int Depth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ssn_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ssn_pkg::entry_t head
);
  import ssn_pkg::*;

  localparam int PtrW = $clog2(Depth);

  entry_t          slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   count;

  assign full       = (count == (PtrW+1)'(Depth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

FILE: sv/ssn_back.sv
// Back end: walks a queued command and emits its driver bytes through an
// output register. Depends on ssn_pkg and seg_if.
module ssn_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  ssn_pkg::entry_t head,
  output logic            pop,
  seg_if.source           seg
);
  import ssn_pkg::*;

  phase_t     phase, phase_next;
  logic [1:0] idx, idx_next;
  logic [1:0] slot;
  logic       out_valid;
  logic       advance, emit;
  logic [7:0] b_byte;
  logic       b_fs, b_fe, b_last;
  logic [3:0] b_pos, b_digit;

  assign advance = !out_valid || seg.ready;
  assign emit    = head_valid && advance;

  // number digits go thousands first to position 3, i.e. position = ~idx
  always_comb begin
    slot    = ~idx;
    b_pos   = (head.kind == KIND_DIGIT) ? head.position : {2'b00, slot};
    b_digit = (head.kind == KIND_DIGIT) ? head.digit : head.bcd[4*slot +: 4];
  end

  always_comb begin
    b_byte     = BYTE_DISPLAY_ON;
    b_fs       = 1'b1;
    b_fe       = 1'b1;
    b_last     = 1'b1;
    phase_next = phase;
    idx_next   = idx;
    if (head.kind == KIND_ON) begin
      phase_next = PHASE_MODE;
      idx_next   = '0;
    end else begin
      case (phase)
        PHASE_MODE: begin
          b_byte     = BYTE_FIXED_ADDR;
          b_last     = 1'b0;
          phase_next = PHASE_ADDR;
        end
        PHASE_ADDR: begin
          b_byte     = BYTE_ADDR_BASE | {4'h0, b_pos};
          b_fe       = 1'b0;
          b_last     = 1'b0;
          phase_next = PHASE_DATA;
        end
        default: begin
          b_byte     = digit_glyph(b_digit);
          b_fs       = 1'b0;
          b_last     = (head.kind == KIND_DIGIT) || (idx == 2'd3);
          phase_next = PHASE_MODE;
          idx_next   = b_last ? 2'd0 : idx + 2'd1;
        end
      endcase
    end
  end

  assign pop = emit && b_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PHASE_MODE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        phase <= phase_next;
        idx   <= idx_next;
      end
      if (advance) out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seg.byte_res    <= b_byte;
      seg.frame_start <= b_fs;
      seg.frame_end   <= b_fe;
      seg.last        <= b_last;
    end
  end

  assign seg.valid = out_valid;

endmodule

FILE: sv/seven_segment_number_command_stream_unit.sv
// Top level of the seven-segment command stream unit.
// Depends on ssn_pkg, cmd_if, seg_if, ssn_front, ssn_queue and ssn_back.
//
// Usage:
//   cmd: valid/ready input, one command per beat (display on, one digit,
//        or a four-digit number). Command code 3 is taken and dropped.
//   seg: valid/ready output, one driver byte per beat with frame_start,
//        frame_end and last marks; last flags the final byte of a command.
// Order: display-on and digit commands go straight into the queue, then
//   through the back end and its output register; a number command first
//   runs a BCD conversion (two bits per cycle) before it is queued.
// Throughput: with seg.ready high the output side moves one byte per cycle;
//   a command yields 1, 3 or 12 bytes. The front end takes one display-on or
//   digit command per cycle while the queue is not full; a number keeps it
//   busy through conversion and push, so its twelve output bytes are the limit.
// The QueueDepth-entry queue lets the front end convert while the back end emits.
// Reset (rst, synchronous) empties the queue and the output register.
// When the receiver holds seg.ready low, the output register holds its byte,
//   the back end stops, the queue fills and then cmd.ready drops.
module seven_segment_number_command_stream_unit #(
  parameter int QueueDepth = 2
) (
  input  logic  clk,
  input  logic  rst,
  cmd_if.sink   cmd,
  seg_if.source seg
);
  import ssn_pkg::*;

  logic   push, full, pop, head_valid;
  entry_t push_entry, head;

  ssn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  ssn_queue #(.Depth(QueueDepth)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ssn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .seg        (seg)
  );

endmodule

FILE: sv/ssn_checker.sv
// Port-level checks for the seven-segment command stream unit, bound to
// the top level. Sees only the output channel and reset.
module ssn_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [7:0] byte_res,
  input logic       frame_start,
  input logic       frame_end,
  input logic       last
);

  // hold a stalled beat
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(byte_res) && $stable(last))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("output valid right after reset");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> frame_end)
    else $error("last byte does not close a frame");

  a_addr_byte: assert property (@(posedge clk) disable iff (rst)
    valid && frame_start && !frame_end |-> byte_res[7:4] == 4'hC)
    else $error("frame opener is not an address byte");

  a_single_frame: assert property (@(posedge clk) disable iff (rst)
    valid && frame_start && frame_end |-> byte_res == 8'h8F || byte_res == 8'h44)
    else $error("single-byte frame carries an unexpected byte");

endmodule

bind seven_segment_number_command_stream_unit ssn_checker u_ssn_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (seg.valid),
  .ready       (seg.ready),
  .byte_res    (seg.byte_res),
  .frame_start (seg.frame_start),
  .frame_end   (seg.frame_end),
  .last        (seg.last)
);

FILE: sim/tb_top.sv
// Testbench for seven_segment_number_command_stream_unit: drives commands,
// predicts the driver byte stream and checks every byte and frame mark.
// Depends on ssn_pkg, cmd_if and seg_if from the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssn_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         N_ITEMS      = 364;
  localparam int         CALM_ITEMS   = 60;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
    logic       fe;
    logic       lst;
  } drv_byte_t;

  class seg_byte_scoreboard;
    drv_byte_t   expected_bytes[$];
    int unsigned kind_seen[4];
    int unsigned bytes_checked;
    int unsigned n_errors;

    function logic [7:0] segment_pattern(input logic [3:0] d);
      logic [7:0] pattern[16];
      pattern = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
                  8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      return pattern[d];
    endfunction

    function void add_digit_frames(input logic [3:0] pos, input logic [3:0] d,
                                   input logic final_one);
      expected_bytes.push_back('{8'h44, 1'b1, 1'b1, 1'b0});
      expected_bytes.push_back('{8'hC0 | {4'h0, pos}, 1'b1, 1'b0, 1'b0});
      expected_bytes.push_back('{segment_pattern(d), 1'b0, 1'b1, final_one});
    endfunction

    // Work out the bytes one accepted command must produce.
    function void note_command(input logic [1:0] c, input logic [3:0] pos,
                               input logic [3:0] d, input logic [15:0] num);
      int unsigned v;
      kind_seen[c]++;
      case (c)
        CMD_ON: begin
          expected_bytes.push_back('{8'h8F, 1'b1, 1'b1, 1'b1});
        end
        CMD_DIGIT: begin
          add_digit_frames(pos, d, 1'b1);
        end
        CMD_NUMBER: begin
          v = (num > 16'd9999) ? 9999 : num;
          add_digit_frames(4'd3, 4'(v / 1000), 1'b0);
          add_digit_frames(4'd2, 4'((v / 100) % 10), 1'b0);
          add_digit_frames(4'd1, 4'((v / 10) % 10), 1'b0);
          add_digit_frames(4'd0, 4'(v % 10), 1'b1);
        end
        default: begin
          // unused code: dropped, nothing comes out
        end
      endcase
    endfunction

    function void check_byte(input drv_byte_t got);
      drv_byte_t want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %h (start %b end %b last %b)",
               got.data, got.fs, got.fe, got.lst);
        n_errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data !== want.data) begin
        $error("byte_res expected %h actual %h", want.data, got.data);
        n_errors++;
      end
      if (got.fs !== want.fs) begin
        $error("frame_start expected %b actual %b", want.fs, got.fs);
        n_errors++;
      end
      if (got.fe !== want.fe) begin
        $error("frame_end expected %b actual %b", want.fe, got.fe);
        n_errors++;
      end
      if (got.lst !== want.lst) begin
        $error("last expected %b actual %b", want.lst, got.lst);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_en = 1'b1;
  int   quiet_cycles = 0;

  seg_byte_scoreboard sb = new();

  cmd_if cmd_ch ();
  seg_if seg_ch ();

  seven_segment_number_command_stream_unit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .seg (seg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels and watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready)
        sb.note_command(cmd_ch.command, cmd_ch.position, cmd_ch.digit, cmd_ch.number);
      if (seg_ch.valid && seg_ch.ready)
        sb.check_byte('{seg_ch.byte_res, seg_ch.frame_start, seg_ch.frame_end,
                        seg_ch.last});
      if ((cmd_ch.valid && cmd_ch.ready) || (seg_ch.valid && seg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Byte receiver: ready in random bursts while idling is enabled.
  initial begin
    seg_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        seg_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        seg_ch.ready <= 1'b1;
        repeat (idle_en ? $urandom_range(1, 12) : 1) @(posedge clk);
      end
    end
  end

  task automatic send_command(input logic [1:0] c, input logic [3:0] pos,
                              input logic [3:0] d, input logic [15:0] num);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.command  <= c;
    cmd_ch.position <= pos;
    cmd_ch.digit    <= d;
    cmd_ch.number   <= num;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [1:0]  c;
    logic [15:0] num;
    pick = $urandom_range(0, 99);
    if (pick < 15)      c = CMD_ON;
    else if (pick < 50) c = CMD_DIGIT;
    else if (pick < 92) c = CMD_NUMBER;
    else                c = CMD_UNUSED;
    case ($urandom_range(0, 3))
      0:       num = 16'($urandom_range(9990, 10010));
      1:       num = 16'($urandom);
      default: num = 16'($urandom_range(0, 9999));
    endcase
    send_command(c, 4'($urandom), 4'($urandom), num);
  endtask

  initial begin
    int sent;
    rst             <= 1'b1;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.command  <= CMD_ON;
    cmd_ch.position <= '0;
    cmd_ch.digit    <= '0;
    cmd_ch.number   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, blank digits, saturation, dropped code
    send_command(CMD_ON, 4'hF, 4'hF, 16'hFFFF);
    send_command(CMD_DIGIT, 4'd0, 4'd0, 16'h0000);
    send_command(CMD_DIGIT, 4'd15, 4'd9, 16'hFFFF);
    send_command(CMD_DIGIT, 4'd5, 4'd10, 16'h1234);
    send_command(CMD_DIGIT, 4'd10, 4'd15, 16'h0000);
    send_command(CMD_DIGIT, 4'd3, 4'd8, 16'h0000);
    send_command(CMD_NUMBER, 4'hF, 4'hF, 16'd0);
    send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd9999);
    send_command(CMD_NUMBER, 4'h5, 4'hA, 16'd10000);
    send_command(CMD_NUMBER, 4'h0, 4'h0, 16'hFFFF);
    send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd1234);
    send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd9087);
    send_command(CMD_NUMBER, 4'h0, 4'h0, 16'd5);
    send_command(CMD_UNUSED, 4'hF, 4'hF, 16'hFFFF);
    send_command(CMD_ON, 4'h0, 4'h0, 16'h0000);
    send_command(CMD_UNUSED, 4'h0, 4'h0, 16'h0000);

    sent = 0;
    while (sent < N_ITEMS) begin
      if (sent == N_ITEMS - CALM_ITEMS)
        idle_en = 1'b0;
      send_random();
      sent++;
    end
    cmd_ch.valid <= 1'b0;

    // drain; the watchdog bounds this wait
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d display-on, %0d digit, %0d number and %0d dropped commands",
             sb.kind_seen[CMD_ON], sb.kind_seen[CMD_DIGIT], sb.kind_seen[CMD_NUMBER],
             sb.kind_seen[CMD_UNUSED]);
    $display("checked %0d driver bytes, %0d mismatches", sb.bytes_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
sv/ssn_pkg.sv
sv/ssn_ifs.sv
sv/ssn_front.sv
sv/ssn_queue.sv
sv/ssn_back.sv
sv/seven_segment_number_command_stream_unit.sv
sv/ssn_checker.sv
sim/tb_top.sv
